// ----- src/fmm_pkg.sv -----
// Shared types and constants of the min-max feature scaler.
// Holds field widths, command and status codes, and the divider handshake structs.
// Depends on nothing.
package fmm_pkg;

  localparam int VALUE_W = 32;
  localparam int DIFF_W  = VALUE_W + 1;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCALE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_STATS = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_rsp_t;

endpackage

// ----- src/feature_min_max_scaler.sv -----
// Min-max feature scaler: top level with command sequencer, statistics store and divider.
// A beat that needs no division has its result strobed from a register set in the lookup state;
// a division goes through the prepare and wait states and the divider at one quotient bit per
// cycle, or ends early when an up-front check finds that the quotient overflows.
// The receiver cannot stall results. Synchronous reset forgets all statistics and sets the
// feature count to 16; the min and max store is not cleared. Depends on fmm_pkg, fmm_ram, fmm_div.
module feature_min_max_scaler #(
  parameter int FEATURES      = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [fmm_pkg::CMD_W-1:0]           in_command,
  input  logic [fmm_pkg::IDX_W-1:0]           in_feature_index,
  input  logic signed [fmm_pkg::VALUE_W-1:0]  in_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fmm_pkg::CNT_W-1:0]           cfg_feature_count,
  output logic                                out_strobe,
  output logic signed [fmm_pkg::VALUE_W-1:0]  out_scaled_value,
  output logic signed [fmm_pkg::VALUE_W-1:0]  out_min_seen,
  output logic signed [fmm_pkg::VALUE_W-1:0]  out_max_seen,
  output logic [fmm_pkg::STAT_W-1:0]          out_status
);
  import fmm_pkg::*;

  localparam int AW = $clog2(FEATURES);
  localparam int XW = IDX_W + AW + 1;
  localparam logic [XW-1:0] FeatLim = XW'(FEATURES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_PREP = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [FEATURES-1:0] seen_r, seen_nxt;
  logic                strobe_r, strobe_nxt;

  logic [CMD_W-1:0]          cmd_r;
  logic [IDX_W-1:0]          idx_r;
  logic signed [VALUE_W-1:0] val_r;
  logic signed [DIFF_W-1:0]  diff_r, diff_nxt;
  logic signed [DIFF_W-1:0]  span_r, span_nxt;
  logic signed [VALUE_W-1:0] scaled_r, scaled_nxt;
  logic signed [VALUE_W-1:0] min_r, min_nxt;
  logic signed [VALUE_W-1:0] max_r, max_nxt;
  logic [STAT_W-1:0]         status_r, status_nxt;

  logic                      accept;
  logic [XW-1:0]             in_idx_x;
  logic [XW-1:0]             idx_x;
  logic [AW-1:0]             raddr;
  logic [AW-1:0]             waddr;
  logic                      we;
  logic [2*VALUE_W-1:0]      rdata;
  logic signed [VALUE_W-1:0] mn_rd;
  logic signed [VALUE_W-1:0] mx_rd;
  logic signed [VALUE_W-1:0] obs_mn;
  logic signed [VALUE_W-1:0] obs_mx;
  logic                      in_range;
  logic                      seen_hit;

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic signed [VALUE_W-1:0] div_quot;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_idx_x  = XW'(in_feature_index);
  assign idx_x     = XW'(idx_r);
  assign raddr     = in_idx_x[AW-1:0];
  assign waddr     = idx_x[AW-1:0];
  assign mn_rd     = rdata[VALUE_W-1:0];
  assign mx_rd     = rdata[2*VALUE_W-1:VALUE_W];
  assign in_range  = (idx_x < XW'(cnt_r)) && (idx_x < FeatLim);
  assign seen_hit  = seen_r[waddr];
  assign obs_mn    = (!seen_hit || (val_r < mn_rd)) ? val_r : mn_rd;
  assign obs_mx    = (!seen_hit || (val_r > mx_rd)) ? val_r : mx_rd;

  fmm_ram #(
    .WIDTH (2 * VALUE_W),
    .DEPTH (FEATURES)
  ) u_stats (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({obs_mx, obs_mn}),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  fmm_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .diff  (diff_r),
    .span  (span_r),
    .quot  (div_quot),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    seen_nxt      = seen_r;
    strobe_nxt    = 1'b0;
    diff_nxt      = diff_r;
    span_nxt      = span_r;
    scaled_nxt    = scaled_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    status_nxt    = status_r;
    we            = 1'b0;
    div_req.start = 1'b0;

    if (cfg_valid && cfg_ready) begin
      cnt_nxt = cfg_feature_count;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        scaled_nxt = '0;
        min_nxt    = '0;
        max_nxt    = '0;
        status_nxt = ST_OK;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (cmd_r == CMD_CLEAR) begin
          seen_nxt = '0;
        end else if ((cmd_r == CMD_OBSERVE) || (cmd_r == CMD_SCALE)) begin
          priority if (!in_range) begin
            status_nxt = ST_RANGE;
          end else if (idx_r == '0) begin
            scaled_nxt = (cmd_r == CMD_SCALE) ? val_r : '0;
          end else if (cmd_r == CMD_OBSERVE) begin
            we              = 1'b1;
            seen_nxt[waddr] = 1'b1;
            min_nxt         = obs_mn;
            max_nxt         = obs_mx;
          end else if (!seen_hit) begin
            status_nxt = ST_NO_STATS;
          end else begin
            min_nxt    = mn_rd;
            max_nxt    = mx_rd;
            diff_nxt   = DIFF_W'(val_r) - DIFF_W'(mn_rd);
            span_nxt   = DIFF_W'(mx_rd) - DIFF_W'(mn_rd);
            strobe_nxt = 1'b0;
            state_nxt  = S_PREP;
          end
        end
      end
      S_PREP: begin
        div_req.start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          scaled_nxt = div_quot;
          status_nxt = div_rsp.sat ? ST_SAT : ST_OK;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= CNT_RESET;
      seen_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      seen_r   <= seen_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      idx_r <= in_feature_index;
      val_r <= in_value;
    end
    diff_r   <= diff_nxt;
    span_r   <= span_nxt;
    scaled_r <= scaled_nxt;
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    status_r <= status_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_scaled_value = scaled_r;
  assign out_min_seen     = min_r;
  assign out_max_seen     = max_r;
  assign out_status       = status_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("Result strobe held for more than one cycle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("Accepted beat did not make the block busy.");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WAIT))
    else $error("Divider finished while no scale was pending.");

  a_no_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && (status_r == ST_NO_STATS)) |-> (scaled_r == '0) && (min_r == '0))
    else $error("Result for a feature without statistics is not zero.");
`endif

endmodule

// ----- src/fmm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the per-feature minimum and maximum store; depends on nothing.
module fmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/fmm_div.sv -----
// Radix-2 restoring divider that forms the signed, saturated scale quotient.
// One quotient bit per cycle after an up-front overflow check.
// Depends on fmm_pkg.
module fmm_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fmm_pkg::div_req_t                   req,
  input  logic signed [fmm_pkg::DIFF_W-1:0]   diff,
  input  logic signed [fmm_pkg::DIFF_W-1:0]   span,
  output logic signed [fmm_pkg::VALUE_W-1:0]  quot,
  output fmm_pkg::div_rsp_t                   rsp
);
  import fmm_pkg::*;

  localparam int DW  = VALUE_W + FRACTION_BITS;
  localparam int CW  = $clog2(VALUE_W);
  localparam logic [VALUE_W-1:0] Unit = {{(VALUE_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_CHECK = 4'b0010,
    D_RUN   = 4'b0100,
    D_FIN   = 4'b1000
  } dstate_t;

  dstate_t state_r, state_nxt;
  logic done_r, done_nxt;
  logic sat_r, sat_nxt;
  logic neg_r, neg_nxt;
  logic ovf_r, ovf_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [VALUE_W-1:0] den_r, den_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [VALUE_W-1:0] lo_r, lo_nxt;
  logic [VALUE_W-1:0] q_r, q_nxt;
  logic [VALUE_W-1:0] quot_r, quot_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic [DIFF_W-1:0]        neg_diff;
  logic [DW-1:0]            dividend;
  logic [FRACTION_BITS-1:0] hi;
  logic [VALUE_W:0]         trial;
  logic [VALUE_W:0]         trial_sub;
  logic                     ge;
  logic                     pos_sat;
  logic                     neg_sat;
  logic                     any_sat;
  logic [VALUE_W-1:0]       q_neg;

  always_comb begin
    neg_diff  = DIFF_W'(-diff);
    dividend  = {mag_r, {FRACTION_BITS{1'b0}}};
    hi        = dividend[DW-1:VALUE_W];
    trial     = {rem_r, lo_r[VALUE_W-1]};
    trial_sub = trial - {1'b0, den_r};
    ge        = (trial >= {1'b0, den_r});
    pos_sat   = !neg_r && q_r[VALUE_W-1];
    neg_sat   = neg_r && q_r[VALUE_W-1] && (|q_r[VALUE_W-2:0]);
    any_sat   = ovf_r || pos_sat || neg_sat;
    q_neg     = VALUE_W'(-q_r);

    state_nxt = state_r;
    done_nxt  = 1'b0;
    sat_nxt   = sat_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    mag_nxt   = mag_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    q_nxt     = q_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;

    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          neg_nxt   = diff[DIFF_W-1];
          mag_nxt   = diff[DIFF_W-1] ? neg_diff[VALUE_W-1:0] : diff[VALUE_W-1:0];
          den_nxt   = (span == '0) ? Unit : span[VALUE_W-1:0];
          state_nxt = D_CHECK;
        end
      end
      D_CHECK: begin
        if (VALUE_W'(hi) >= den_r) begin
          ovf_nxt   = 1'b1;
          state_nxt = D_FIN;
        end else begin
          ovf_nxt   = 1'b0;
          rem_nxt   = VALUE_W'(hi);
          lo_nxt    = dividend[VALUE_W-1:0];
          q_nxt     = '0;
          cnt_nxt   = CW'(VALUE_W - 1);
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? trial_sub[VALUE_W-1:0] : trial[VALUE_W-1:0];
        lo_nxt  = lo_r << 1;
        q_nxt   = {q_r[VALUE_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = D_FIN;
        end
      end
      D_FIN: begin
        sat_nxt = any_sat;
        if (any_sat) begin
          quot_nxt = neg_r ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
          quot_nxt = neg_r ? q_neg : q_r;
        end
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sat_r  <= sat_nxt;
    neg_r  <= neg_nxt;
    ovf_r  <= ovf_nxt;
    mag_r  <= mag_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    q_r    <= q_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign quot     = quot_r;
  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;

endmodule
